>>> src/rcn_pkg.sv
package rcn_pkg;

  // default log depth, register reset values, lfsr taps and counter limits
  localparam int unsigned LogDepthDef   = 1024;
  localparam logic [3:0]  OwnIdRst      = 4'd0;
  localparam logic [4:0]  ClusterRst    = 5'd3;
  localparam logic [8:0]  TminRst       = 9'd150;
  localparam logic [8:0]  TspanRst      = 9'd150;
  localparam logic [15:0] SeedRst       = 16'd44257;
  localparam logic [15:0] LfsrTaps      = 16'hB400;
  localparam logic [9:0]  ElapsedMax    = 10'd1023;
  localparam logic [4:0]  VotesMax      = 5'd31;

  // event opcodes
  localparam logic [2:0] OP_VOTE_REQ  = 3'd0;
  localparam logic [2:0] OP_APPEND    = 3'd1;
  localparam logic [2:0] OP_SUBMIT    = 3'd2;
  localparam logic [2:0] OP_VOTE_RPLY = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // roles
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  // reply status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_STALE      = 3'd1;
  localparam logic [2:0] ST_MISMATCH   = 3'd2;
  localparam logic [2:0] ST_NOT_LEADER = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_REFUSED    = 3'd5;

  // register indexes
  localparam logic [2:0] REG_OWN_ID  = 3'd0;
  localparam logic [2:0] REG_CLUSTER = 3'd1;
  localparam logic [2:0] REG_TMIN    = 3'd2;
  localparam logic [2:0] REG_TSPAN   = 3'd3;
  localparam logic [2:0] REG_SEED    = 3'd4;

  typedef struct packed {
    logic [3:0] own_id;
    logic [4:0] cluster_size;
    logic [8:0] timeout_min;
    logic [8:0] timeout_span;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_run;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic div_last;
  } stat_t;

endpackage

>>> src/rcn_ram.sv
module rcn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/rcn_ctrl.sv
module rcn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rcn_pkg::stat_t stat,
  output rcn_pkg::cmd_t  cmd,
  output logic          busy
);
  import rcn_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.restart ? S_DIV : S_IDLE;
      S_DIV:  if (stat.div_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands to the datapath
  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.div_run = (state_r == S_DIV);

endmodule

>>> src/rcn_dp.sv
module rcn_dp #(
  parameter int unsigned LOG_DEPTH = rcn_pkg::LogDepthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rcn_pkg::cfg_t cfg,
  input  logic          seed_load,
  input  logic [15:0]   seed_val,
  input  rcn_pkg::cmd_t cmd,
  output rcn_pkg::stat_t stat,
  input  logic [2:0]    in_opcode,
  input  logic [31:0]   in_msg_term,
  input  logic [3:0]    in_sender_id,
  input  logic [31:0]   in_ref_log_index,
  input  logic [31:0]   in_ref_log_term,
  input  logic [31:0]   in_leader_commit,
  input  logic          in_granted_in,
  output logic          out_valid,
  output logic [31:0]   out_reply_term,
  output logic          out_ok,
  output logic [2:0]    out_status,
  output logic [1:0]    out_role,
  output logic          out_election_started,
  output logic [9:0]    out_last_index,
  output logic [31:0]   out_last_term,
  output logic [9:0]    out_commit_out
);
  import rcn_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam logic [AW-1:0] TailFull = AW'(LOG_DEPTH - 1);

  // captured item
  logic [2:0]  op_r;
  logic [31:0] term_in_r, ref_idx_r, ref_term_r, lcommit_r;
  logic [3:0]  sender_r;
  logic        granted_r, ref_zero_r;

  // node state
  logic [31:0]   cur_term_r, cur_term_nxt;
  logic [1:0]    role_r, role_nxt;
  logic          voted_r, voted_nxt;
  logic [3:0]    voted_for_r, voted_for_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] commit_r, commit_nxt;
  logic [31:0]   last_term_r, last_term_nxt;
  logic [9:0]    elapsed_r, elapsed_nxt;
  logic [9:0]    timeout_r, timeout_nxt;
  logic [15:0]   lfsr_r, lfsr_nxt;
  logic [4:0]    votes_r, votes_nxt;

  // remainder unit
  logic [9:0] rem_r, rem_nxt;
  logic [3:0] div_cnt_r;
  logic [9:0] divisor;
  logic [10:0] trial;

  // log memory
  logic          mem_we;
  logic [31:0]   mem_rdata;
  logic [31:0]   entry_term;

  // step results
  logic        ok, started, restart;
  logic [2:0]  status;
  logic [15:0] lfsr_step;
  logic [4:0]  votes_inc;
  logic [9:0]  elapsed_inc;
  logic        fresh;

  logic        out_valid_r;
  logic [31:0] out_term_r, out_last_term_r;
  logic        out_ok_r, out_started_r;
  logic [2:0]  out_status_r;
  logic [1:0]  out_role_r;
  logic [9:0]  out_last_index_r, out_commit_r;

  rcn_ram #(
    .WIDTH (32),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r + AW'(1)),
    .wdata (cur_term_r),
    .raddr (in_ref_log_index[AW-1:0]),
    .rdata (mem_rdata)
  );

  // entry zero is the fixed dummy entry of term zero
  assign entry_term = ref_zero_r ? 32'd0 : mem_rdata;

  // one lfsr step with the all-zero value mapped to one
  always_comb begin
    lfsr_step = lfsr_r >> 1;
    if (lfsr_r[0]) begin
      lfsr_step = lfsr_step ^ LfsrTaps;
    end
    if (lfsr_step == 16'd0) begin
      lfsr_step = 16'd1;
    end
  end

  assign votes_inc   = (votes_r < VotesMax) ? votes_r + 5'd1 : votes_r;
  assign elapsed_inc = (elapsed_r < ElapsedMax) ? elapsed_r + 10'd1 : elapsed_r;

  // event handling
  always_comb begin
    cur_term_nxt  = cur_term_r;
    role_nxt      = role_r;
    voted_nxt     = voted_r;
    voted_for_nxt = voted_for_r;
    tail_nxt      = tail_r;
    commit_nxt    = commit_r;
    last_term_nxt = last_term_r;
    elapsed_nxt   = elapsed_r;
    votes_nxt     = votes_r;
    ok            = 1'b0;
    started       = 1'b0;
    restart       = 1'b0;
    status        = ST_OK;
    mem_we        = 1'b0;
    fresh         = (ref_term_r > last_term_r) ||
                    ((ref_term_r == last_term_r) && (ref_idx_r >= 32'(tail_r)));
    unique case (op_r)
      OP_VOTE_REQ: begin
        if (term_in_r < cur_term_r) begin
          status = ST_STALE;
        end else begin
          if (term_in_r > cur_term_r) begin
            cur_term_nxt  = term_in_r;
            role_nxt      = ROLE_FOLLOWER;
            voted_nxt     = 1'b0;
            voted_for_nxt = 4'd0;
          end
          if ((!voted_nxt || voted_for_nxt == sender_r) && fresh) begin
            voted_nxt     = 1'b1;
            voted_for_nxt = sender_r;
            ok            = 1'b1;
            restart       = 1'b1;
          end else begin
            status = ST_REFUSED;
          end
        end
      end
      OP_APPEND: begin
        if (term_in_r < cur_term_r) begin
          status = ST_STALE;
        end else begin
          if (term_in_r > cur_term_r) begin
            voted_nxt     = 1'b0;
            voted_for_nxt = 4'd0;
          end
          role_nxt     = ROLE_FOLLOWER;
          cur_term_nxt = term_in_r;
          restart      = 1'b1;
          if ((ref_idx_r > 32'(tail_r)) || (entry_term != ref_term_r)) begin
            status = ST_MISMATCH;
          end else begin
            if (lcommit_r > 32'(commit_r)) begin
              commit_nxt = (lcommit_r < 32'(tail_r)) ? lcommit_r[AW-1:0] : tail_r;
            end
            ok = 1'b1;
          end
        end
      end
      OP_SUBMIT: begin
        if (role_r != ROLE_LEADER) begin
          status = ST_NOT_LEADER;
        end else if (tail_r == TailFull) begin
          status = ST_FULL;
        end else begin
          tail_nxt      = tail_r + AW'(1);
          last_term_nxt = cur_term_r;
          mem_we        = 1'b1;
          ok            = 1'b1;
        end
      end
      OP_VOTE_RPLY: begin
        if (term_in_r < cur_term_r) begin
          status = ST_STALE;
        end else if (term_in_r > cur_term_r) begin
          cur_term_nxt  = term_in_r;
          role_nxt      = ROLE_FOLLOWER;
          voted_nxt     = 1'b0;
          voted_for_nxt = 4'd0;
        end else if (role_r == ROLE_CANDIDATE && granted_r) begin
          votes_nxt = votes_inc;
          ok        = 1'b1;
          if ({votes_inc, 1'b0} > {1'b0, cfg.cluster_size}) begin
            role_nxt = ROLE_LEADER;
          end
        end
      end
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (role_r != ROLE_LEADER && elapsed_inc >= timeout_r) begin
          role_nxt      = ROLE_CANDIDATE;
          cur_term_nxt  = cur_term_r + 32'd1;
          voted_nxt     = 1'b1;
          voted_for_nxt = cfg.own_id;
          votes_nxt     = 5'd1;
          restart       = 1'b1;
          started       = 1'b1;
          if (cfg.cluster_size < 5'd2) begin
            role_nxt = ROLE_LEADER;
          end
        end
      end
      default: begin
      end
    endcase
    if (restart) begin
      elapsed_nxt = 10'd0;
    end
  end

  // bit-serial remainder of the lfsr value by span plus one
  assign divisor = {1'b0, cfg.timeout_span} + 10'd1;
  assign trial   = {rem_r, lfsr_r[4'd15 - div_cnt_r]};
  assign rem_nxt = (trial >= {1'b0, divisor}) ? 10'(trial - {1'b0, divisor}) : trial[9:0];

  always_comb begin
    lfsr_nxt    = lfsr_r;
    timeout_nxt = timeout_r;
    if (seed_load) begin
      lfsr_nxt = (seed_val == 16'd0) ? 16'd1 : seed_val;
    end else if (cmd.exec && restart) begin
      lfsr_nxt = lfsr_step;
    end
    if (cmd.div_run && stat.div_last) begin
      timeout_nxt = {1'b0, cfg.timeout_min} + rem_nxt;
    end
  end

  assign stat.restart  = restart;
  assign stat.div_last = (div_cnt_r == 4'd15);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_term_r  <= 32'd0;
      role_r      <= ROLE_FOLLOWER;
      voted_r     <= 1'b0;
      voted_for_r <= 4'd0;
      tail_r      <= '0;
      commit_r    <= '0;
      last_term_r <= 32'd0;
      elapsed_r   <= 10'd0;
      timeout_r   <= {1'b0, TminRst};
      lfsr_r      <= SeedRst;
      votes_r     <= 5'd0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= 4'd0;
    end else begin
      lfsr_r      <= lfsr_nxt;
      timeout_r   <= timeout_nxt;
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        cur_term_r  <= cur_term_nxt;
        role_r      <= role_nxt;
        voted_r     <= voted_nxt;
        voted_for_r <= voted_for_nxt;
        tail_r      <= tail_nxt;
        commit_r    <= commit_nxt;
        last_term_r <= last_term_nxt;
        elapsed_r   <= elapsed_nxt;
        votes_r     <= votes_nxt;
        div_cnt_r   <= 4'd0;
      end else if (cmd.div_run) begin
        div_cnt_r <= div_cnt_r + 4'd1;
      end
    end
  end

  // item capture, remainder and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_opcode;
      term_in_r  <= in_msg_term;
      sender_r   <= in_sender_id;
      ref_idx_r  <= in_ref_log_index;
      ref_term_r <= in_ref_log_term;
      lcommit_r  <= in_leader_commit;
      granted_r  <= in_granted_in;
      ref_zero_r <= (in_ref_log_index[AW-1:0] == '0);
    end
    if (cmd.exec) begin
      rem_r            <= 10'd0;
      out_term_r       <= cur_term_nxt;
      out_ok_r         <= ok;
      out_status_r     <= status;
      out_role_r       <= role_nxt;
      out_started_r    <= started;
      out_last_index_r <= 10'(tail_nxt);
      out_last_term_r  <= last_term_nxt;
      out_commit_r     <= 10'(commit_nxt);
    end else if (cmd.div_run) begin
      rem_r <= rem_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_reply_term       = out_term_r;
  assign out_ok               = out_ok_r;
  assign out_status           = out_status_r;
  assign out_role             = out_role_r;
  assign out_election_started = out_started_r;
  assign out_last_index       = out_last_index_r;
  assign out_last_term        = out_last_term_r;
  assign out_commit_out       = out_commit_r;

endmodule

>>> src/raft_consensus_node.sv
// raft node: election and log bookkeeping, one event per command
// input: raise start with the in_ fields while busy is low; the event is
//   taken at that edge (vote request, append, submit, vote reply, tick)
// output: one result per event, shown for one cycle with out_valid high;
//   the event is decided in the cycle after it is taken and the result
//   shows in the cycle after that; the receiver cannot stall
// steps: capture with log memory read, then decide; an event that
//   restarts the election timer keeps busy high while a bit-serial
//   remainder unit draws the new timeout; no new event is taken
//   until busy is low again
// config: apb port, registers at byte addresses 0,4,8,12,16 (own id,
//   cluster size, timeout min, timeout span, lfsr seed); write only
//   while idle; pready is always high
// reset: synchronous, active low; role follower, term zero, empty log,
//   registers at their defaults; the log memory needs no clearing pass
module raft_consensus_node #(
  parameter int unsigned LOG_DEPTH = rcn_pkg::LogDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_msg_term,
  input  logic [3:0]  in_sender_id,
  input  logic [31:0] in_ref_log_index,
  input  logic [31:0] in_ref_log_term,
  input  logic [31:0] in_leader_commit,
  input  logic        in_granted_in,
  output logic        out_valid,
  output logic [31:0] out_reply_term,
  output logic        out_ok,
  output logic [2:0]  out_status,
  output logic [1:0]  out_role,
  output logic        out_election_started,
  output logic [9:0]  out_last_index,
  output logic [31:0] out_last_term,
  output logic [9:0]  out_commit_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcn_pkg::*;

  cfg_t        cfg_r;
  logic [15:0] seed_r;
  logic        wr_en, seed_load;
  logic [2:0]  reg_idx;
  cmd_t        cmd;
  stat_t       stat;

  // register file
  assign reg_idx   = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign seed_load = wr_en && (reg_idx == REG_SEED);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id       <= OwnIdRst;
      cfg_r.cluster_size <= ClusterRst;
      cfg_r.timeout_min  <= TminRst;
      cfg_r.timeout_span <= TspanRst;
      seed_r             <= SeedRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OWN_ID:  cfg_r.own_id       <= pwdata[3:0];
        REG_CLUSTER: cfg_r.cluster_size <= pwdata[4:0];
        REG_TMIN:    cfg_r.timeout_min  <= pwdata[8:0];
        REG_TSPAN:   cfg_r.timeout_span <= pwdata[8:0];
        REG_SEED:    seed_r             <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_OWN_ID:  prdata = {28'd0, cfg_r.own_id};
      REG_CLUSTER: prdata = {27'd0, cfg_r.cluster_size};
      REG_TMIN:    prdata = {23'd0, cfg_r.timeout_min};
      REG_TSPAN:   prdata = {23'd0, cfg_r.timeout_span};
      REG_SEED:    prdata = {16'd0, seed_r};
      default:     prdata = 32'd0;
    endcase
  end

  rcn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rcn_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .seed_load            (seed_load),
    .seed_val             (pwdata[15:0]),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_opcode            (in_opcode),
    .in_msg_term          (in_msg_term),
    .in_sender_id         (in_sender_id),
    .in_ref_log_index     (in_ref_log_index),
    .in_ref_log_term      (in_ref_log_term),
    .in_leader_commit     (in_leader_commit),
    .in_granted_in        (in_granted_in),
    .out_valid            (out_valid),
    .out_reply_term       (out_reply_term),
    .out_ok               (out_ok),
    .out_status           (out_status),
    .out_role             (out_role),
    .out_election_started (out_election_started),
    .out_last_index       (out_last_index),
    .out_last_term        (out_last_term),
    .out_commit_out       (out_commit_out)
  );

endmodule
